/* hw/rtl/scdef_pkg.sv */
// Shared types, constants and key tables for the scancode decoder with event FIFO.
`default_nettype none

package scdef_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int TYPE_W     = 5;
    localparam int CHAR_W     = 7;
    localparam int EVENT_W    = TYPE_W + CHAR_W;

    typedef enum logic [0:0] {
        REQ_SCAN = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    localparam logic [TYPE_W-1:0] EV_NONE     = 5'd0;
    localparam logic [TYPE_W-1:0] EV_CHAR     = 5'd1;
    localparam logic [TYPE_W-1:0] EV_BKSP     = 5'd2;
    localparam logic [TYPE_W-1:0] EV_ENTER    = 5'd3;
    localparam logic [TYPE_W-1:0] EV_TAB      = 5'd4;
    localparam logic [TYPE_W-1:0] EV_UP       = 5'd5;
    localparam logic [TYPE_W-1:0] EV_DOWN     = 5'd6;
    localparam logic [TYPE_W-1:0] EV_LEFT     = 5'd7;
    localparam logic [TYPE_W-1:0] EV_RIGHT    = 5'd8;
    localparam logic [TYPE_W-1:0] EV_PGUP     = 5'd9;
    localparam logic [TYPE_W-1:0] EV_PGDN     = 5'd10;
    localparam logic [TYPE_W-1:0] EV_HOME     = 5'd11;
    localparam logic [TYPE_W-1:0] EV_END      = 5'd12;
    localparam logic [TYPE_W-1:0] EV_INSERT   = 5'd13;
    localparam logic [TYPE_W-1:0] EV_DELETE   = 5'd14;
    localparam logic [TYPE_W-1:0] EV_CTRL_C   = 5'd15;
    localparam logic [TYPE_W-1:0] EV_CTRL_S   = 5'd16;
    localparam logic [TYPE_W-1:0] EV_CTRL_X   = 5'd17;
    localparam logic [TYPE_W-1:0] EV_CTRL_K   = 5'd18;
    localparam logic [TYPE_W-1:0] EV_CTRL_V   = 5'd19;
    localparam logic [TYPE_W-1:0] EV_CTRL_A   = 5'd20;
    localparam logic [TYPE_W-1:0] EV_CTRL_Q   = 5'd21;
    localparam logic [TYPE_W-1:0] EV_CTRL_PLS = 5'd22;
    localparam logic [TYPE_W-1:0] EV_CTRL_MIN = 5'd23;
    localparam logic [TYPE_W-1:0] EV_CTRL_Z   = 5'd24;
    localparam logic [TYPE_W-1:0] EV_CTRL_SZ  = 5'd25;

    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_CTRL     = 7'h1D;
    localparam logic [7:0] SC_BKSP     = 8'h0E;
    localparam logic [7:0] SC_ENTER    = 8'h1C;
    localparam logic [7:0] SC_TAB      = 8'h0F;
    localparam logic [7:0] SC_ROM_LEN  = 8'h3A;

    typedef struct packed {
        req_kind_t  req_type;
        logic [7:0] scancode;
    } scan_req_t;

    typedef struct packed {
        logic [TYPE_W-1:0] event_type;
        logic [CHAR_W-1:0] event_char;
        logic              shift_down;
        logic              dropped;
    } key_report_t;

    typedef struct packed {
        logic              prefix;
        logic              shift;
        logic              ctrl;
        logic              ev_valid;
        logic [EVENT_W-1:0] ev_word;
    } dec_result_t;

    function automatic logic [TYPE_W-1:0] nav_code(input logic [7:0] sc);
        logic [TYPE_W-1:0] t;
        case (sc)
            8'h48:   t = EV_UP;
            8'h50:   t = EV_DOWN;
            8'h4B:   t = EV_LEFT;
            8'h4D:   t = EV_RIGHT;
            8'h49:   t = EV_PGUP;
            8'h51:   t = EV_PGDN;
            8'h47:   t = EV_HOME;
            8'h4F:   t = EV_END;
            8'h52:   t = EV_INSERT;
            8'h53:   t = EV_DELETE;
            default: t = EV_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [TYPE_W-1:0] ctrl_code(input logic [7:0] sc, input logic shift);
        logic [TYPE_W-1:0] t;
        case (sc)
            8'h2E:   t = EV_CTRL_C;
            8'h1F:   t = EV_CTRL_S;
            8'h2D:   t = EV_CTRL_X;
            8'h25:   t = EV_CTRL_K;
            8'h2F:   t = EV_CTRL_V;
            8'h1E:   t = EV_CTRL_A;
            8'h10:   t = EV_CTRL_Q;
            8'h0D:   t = EV_CTRL_PLS;
            8'h0C:   t = EV_CTRL_MIN;
            8'h2C:   t = shift ? EV_CTRL_SZ : EV_CTRL_Z;
            default: t = EV_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [CHAR_W-1:0] rom_plain(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h31;
            6'd3:    c = 7'h32;
            6'd4:    c = 7'h33;
            6'd5:    c = 7'h34;
            6'd6:    c = 7'h35;
            6'd7:    c = 7'h36;
            6'd8:    c = 7'h37;
            6'd9:    c = 7'h38;
            6'd10:   c = 7'h39;
            6'd11:   c = 7'h30;
            6'd12:   c = 7'h2D;
            6'd13:   c = 7'h3D;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h71;
            6'd17:   c = 7'h77;
            6'd18:   c = 7'h65;
            6'd19:   c = 7'h72;
            6'd20:   c = 7'h74;
            6'd21:   c = 7'h79;
            6'd22:   c = 7'h75;
            6'd23:   c = 7'h69;
            6'd24:   c = 7'h6F;
            6'd25:   c = 7'h70;
            6'd26:   c = 7'h5B;
            6'd27:   c = 7'h5D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h61;
            6'd31:   c = 7'h73;
            6'd32:   c = 7'h64;
            6'd33:   c = 7'h66;
            6'd34:   c = 7'h67;
            6'd35:   c = 7'h68;
            6'd36:   c = 7'h6A;
            6'd37:   c = 7'h6B;
            6'd38:   c = 7'h6C;
            6'd39:   c = 7'h3B;
            6'd40:   c = 7'h27;
            6'd41:   c = 7'h60;
            6'd43:   c = 7'h5C;
            6'd44:   c = 7'h7A;
            6'd45:   c = 7'h78;
            6'd46:   c = 7'h63;
            6'd47:   c = 7'h76;
            6'd48:   c = 7'h62;
            6'd49:   c = 7'h6E;
            6'd50:   c = 7'h6D;
            6'd51:   c = 7'h2C;
            6'd52:   c = 7'h2E;
            6'd53:   c = 7'h2F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rom_shift(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h21;
            6'd3:    c = 7'h40;
            6'd4:    c = 7'h23;
            6'd5:    c = 7'h24;
            6'd6:    c = 7'h25;
            6'd7:    c = 7'h5E;
            6'd8:    c = 7'h26;
            6'd9:    c = 7'h2A;
            6'd10:   c = 7'h28;
            6'd11:   c = 7'h29;
            6'd12:   c = 7'h5F;
            6'd13:   c = 7'h2B;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h51;
            6'd17:   c = 7'h57;
            6'd18:   c = 7'h45;
            6'd19:   c = 7'h52;
            6'd20:   c = 7'h54;
            6'd21:   c = 7'h59;
            6'd22:   c = 7'h55;
            6'd23:   c = 7'h49;
            6'd24:   c = 7'h4F;
            6'd25:   c = 7'h50;
            6'd26:   c = 7'h7B;
            6'd27:   c = 7'h7D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h41;
            6'd31:   c = 7'h53;
            6'd32:   c = 7'h44;
            6'd33:   c = 7'h46;
            6'd34:   c = 7'h47;
            6'd35:   c = 7'h48;
            6'd36:   c = 7'h4A;
            6'd37:   c = 7'h4B;
            6'd38:   c = 7'h4C;
            6'd39:   c = 7'h3A;
            6'd40:   c = 7'h22;
            6'd41:   c = 7'h7E;
            6'd43:   c = 7'h7C;
            6'd44:   c = 7'h5A;
            6'd45:   c = 7'h58;
            6'd46:   c = 7'h43;
            6'd47:   c = 7'h56;
            6'd48:   c = 7'h42;
            6'd49:   c = 7'h4E;
            6'd50:   c = 7'h4D;
            6'd51:   c = 7'h3C;
            6'd52:   c = 7'h3E;
            6'd53:   c = 7'h3F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/scancode_decoder_event_fifo_core.sv */
// Top level: scancode decoder feeding a RAM-based ring FIFO of key events.
//
//   Channel | Handshake            | Payload            | Transfer
//   --------+----------------------+--------------------+------------------------------
//   request | req_valid/req_ready  | req (scan_req_t)   | one scancode byte or one read
//   result  | evt_valid/evt_ready  | evt (key_report_t) | exactly one per request
//
// One request transfer is taken every cycle while the output does not stall the pipeline.
// The rate is set by the event RAM, which takes one write and one read per cycle.
// A request moves into a stage that holds the RAM read data, then into the output
// register, so one more request is taken while a result waits on a stalled output.
// Reset clears the pointers, modifier flags and valid bits; the RAM is not cleared.
`default_nettype none

module scancode_decoder_event_fifo_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire scdef_pkg::scan_req_t  req,
    output logic                       evt_valid,
    input  wire logic                  evt_ready,
    output scdef_pkg::key_report_t     evt
);

    logic [scdef_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [scdef_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [scdef_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [scdef_pkg::PTR_W-1:0]   rd_ptr_next;
    logic [scdef_pkg::PTR_W-1:0]   wr_ptr_inc;
    logic [scdef_pkg::PTR_W-1:0]   rd_ptr_inc;
    logic                          prefix_reg;
    logic                          prefix_next;
    logic                          shift_reg;
    logic                          shift_next;
    logic                          ctrl_reg;
    logic                          ctrl_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_hit_reg;
    logic                          s1_hit_next;
    logic                          s1_shift_reg;
    logic                          s1_shift_next;
    logic                          s1_drop_reg;
    logic                          s1_drop_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    scdef_pkg::key_report_t        out_reg;
    scdef_pkg::key_report_t        out_next;

    scdef_pkg::dec_result_t        dec;
    logic [scdef_pkg::EVENT_W-1:0] rd_data;
    logic                          accept;
    logic                          is_scan;
    logic                          empty;
    logic                          full;
    logic                          wr_en;
    logic                          rd_en;
    logic                          s1_move;

    scdef_decode u_decode (
        .prefix   (prefix_reg),
        .shift    (shift_reg),
        .ctrl     (ctrl_reg),
        .scancode (req.scancode),
        .result   (dec)
    );

    scdef_ram #(
        .WIDTH (scdef_pkg::EVENT_W),
        .DEPTH (scdef_pkg::FIFO_DEPTH)
    ) u_event_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (dec.ev_word),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    assign wr_ptr_inc = (wr_ptr_reg == scdef_pkg::PTR_W'(scdef_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == scdef_pkg::PTR_W'(scdef_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);

    assign s1_move   = !out_valid_reg || evt_ready;
    assign req_ready = !s1_valid_reg || s1_move;
    assign accept    = req_valid && req_ready;
    assign is_scan   = (req.req_type == scdef_pkg::REQ_SCAN);
    assign wr_en     = accept && is_scan && dec.ev_valid && !full;
    assign rd_en     = accept && !is_scan && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_inc : rd_ptr_reg;
        prefix_next = prefix_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        if (accept && is_scan)
        begin
            prefix_next = dec.prefix;
            shift_next  = dec.shift;
            ctrl_next   = dec.ctrl;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_hit_next   = s1_hit_reg;
        s1_shift_next = s1_shift_reg;
        s1_drop_next  = s1_drop_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_hit_next   = rd_en;
            s1_shift_next = is_scan ? dec.shift : shift_reg;
            s1_drop_next  = is_scan && dec.ev_valid && full;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_next.event_type = s1_hit_reg ? rd_data[scdef_pkg::EVENT_W-1:scdef_pkg::CHAR_W]
                                                 : scdef_pkg::EV_NONE;
                out_next.event_char = s1_hit_reg ? rd_data[scdef_pkg::CHAR_W-1:0] : '0;
                out_next.shift_down = s1_shift_reg;
                out_next.dropped    = s1_drop_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            prefix_reg    <= 1'b0;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            prefix_reg    <= prefix_next;
            shift_reg     <= shift_next;
            ctrl_reg      <= ctrl_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg   <= s1_hit_next;
        s1_shift_reg <= s1_shift_next;
        s1_drop_reg  <= s1_drop_next;
        out_reg      <= out_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // A dropped event never carries event data in its result.
    a_drop_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.dropped |-> out_reg.event_type == scdef_pkg::EV_NONE)
        else $error("dropped result carries an event");

    // A queued event leaves the FIFO non-empty in the next cycle.
    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !empty)
        else $error("FIFO empty right after a write");

    // A read from a non-empty FIFO advances the read pointer.
    a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> rd_ptr_reg != $past(rd_ptr_reg))
        else $error("read pointer did not advance");

    // The request side is held back only while the middle stage is occupied and the output is stalled.
    a_ready_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && out_valid_reg)
        else $error("request stalled with room in the pipeline");

    // A stage result that moves on is valid at the output in the next cycle.
    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_move |=> out_valid_reg)
        else $error("stage result lost on the way to the output");

endmodule

`default_nettype wire

/* hw/rtl/scdef_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module scdef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scdef_decode.sv */
// Scancode set 1 decoder: modifier tracking and key event lookup for one byte.
`default_nettype none

module scdef_decode (
    input  wire logic                 prefix,
    input  wire logic                 shift,
    input  wire logic                 ctrl,
    input  wire logic [7:0]           scancode,
    output scdef_pkg::dec_result_t    result
);

    logic [scdef_pkg::TYPE_W-1:0] ev_type;
    logic [scdef_pkg::CHAR_W-1:0] ev_char;
    logic                         prefix_new;
    logic                         shift_new;
    logic                         ctrl_new;
    logic [6:0]                   key;

    assign key = scancode[6:0];

    always_comb
    begin
        prefix_new = prefix;
        shift_new  = shift;
        ctrl_new   = ctrl;
        ev_type    = scdef_pkg::EV_NONE;
        ev_char    = '0;
        if (scancode == scdef_pkg::SC_PREFIX)
        begin
            prefix_new = 1'b1;
        end
        else if (scancode[7])
        begin
            if (key == scdef_pkg::SC_LSHIFT || key == scdef_pkg::SC_RSHIFT)
            begin
                shift_new = 1'b0;
            end
            else if (key == scdef_pkg::SC_CTRL)
            begin
                ctrl_new = 1'b0;
            end
            prefix_new = 1'b0;
        end
        else if (key == scdef_pkg::SC_CTRL)
        begin
            ctrl_new   = 1'b1;
            prefix_new = 1'b0;
        end
        else if (key == scdef_pkg::SC_LSHIFT || key == scdef_pkg::SC_RSHIFT)
        begin
            shift_new  = 1'b1;
            prefix_new = 1'b0;
        end
        else if (prefix)
        begin
            ev_type    = scdef_pkg::nav_code(scancode);
            prefix_new = 1'b0;
        end
        else if (ctrl)
        begin
            ev_type = scdef_pkg::ctrl_code(scancode, shift);
        end
        else if (scancode == scdef_pkg::SC_BKSP)
        begin
            ev_type = scdef_pkg::EV_BKSP;
        end
        else if (scancode == scdef_pkg::SC_ENTER)
        begin
            ev_type = scdef_pkg::EV_ENTER;
        end
        else if (scancode == scdef_pkg::SC_TAB)
        begin
            ev_type = scdef_pkg::EV_TAB;
        end
        else if (scancode < scdef_pkg::SC_ROM_LEN)
        begin
            ev_char = shift ? scdef_pkg::rom_shift(scancode[5:0])
                            : scdef_pkg::rom_plain(scancode[5:0]);
            if (ev_char != '0)
            begin
                ev_type = scdef_pkg::EV_CHAR;
            end
        end
    end

    assign result.prefix   = prefix_new;
    assign result.shift    = shift_new;
    assign result.ctrl     = ctrl_new;
    assign result.ev_valid = (ev_type != scdef_pkg::EV_NONE);
    assign result.ev_word  = {ev_type, ev_char};

endmodule

`default_nettype wire
